FILE: hdl/lpd_pkg.sv
package lpd_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned MAXLEN_W  = 15;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_W     = 16;

    // register reset values
    localparam logic [LEN_W-1:0]    SEED_RESET        = 16'd1606;
    localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RESET = 15'd4096;

    // compress byte value that marks a compressed frame
    localparam logic [BYTE_W-1:0] COMPRESS_MARK = 8'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

    // frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_VERIFY     = 2'd1,
        ST_TOO_LONG   = 2'd2,
        ST_COMPRESSED = 2'd3
    } t_status;

    // header position; code 7 is unused and handled as payload
    typedef enum logic [2:0] {
        HP_LEN_HI   = 3'd0,
        HP_LEN_LO   = 3'd1,
        HP_VER_HI   = 3'd2,
        HP_VER_LO   = 3'd3,
        HP_COMPRESS = 3'd4,
        HP_CHECKSUM = 3'd5,
        HP_PAYLOAD  = 3'd6
    } t_hdr_pos;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_status           status;
        logic              last;
    } t_result;

endpackage

FILE: hdl/length_prefixed_deframer_core.sv
// each result is registered in the output register, or in the skid entry if that stays full
// rate: one byte per cycle unless stalled; header and non-last flagged bytes give no result
// input ready stays high until the two-entry output buffer (register plus skid) is full
// reset (synchronous, active low): header search restarts, output buffer empties,
// seed returns to 1606 and max payload to 4096
module length_prefixed_deframer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]     i_rx_byte,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpd_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [lpd_pkg::STATUS_W-1:0]   o_frame_status,
    output logic                           o_frame_last,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpd_pkg::CFG_W-1:0]      i_cfg_data
);
    import lpd_pkg::*;

    logic [LEN_W-1:0]    r_seed;
    logic [MAXLEN_W-1:0] r_max_payload;

    logic    rx_accept;
    logic    out_take;
    logic    res_valid;
    t_result res;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_skid_valid;
    assign rx_accept   = i_rx_valid && o_rx_ready;
    assign out_take    = r_out_valid && i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= SEED_RESET;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEED:        r_seed        <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    lpd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (rx_accept),
        .i_rx_byte     (i_rx_byte),
        .i_seed        (r_seed),
        .i_max_payload (r_max_payload),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // output register with skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (res_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_frame_status = r_out.status;
    assign o_frame_last   = r_out.last;

endmodule

FILE: hdl/lpd_parser.sv
module lpd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lpd_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic [lpd_pkg::LEN_W-1:0]     i_seed,
    input  logic [lpd_pkg::MAXLEN_W-1:0]  i_max_payload,
    output logic                          o_res_valid,
    output lpd_pkg::t_result              o_res
);
    import lpd_pkg::*;

    t_hdr_pos            r_hdr_pos, n_hdr_pos;
    logic [LEN_W-1:0]    r_frame_len, n_frame_len;
    logic [LEN_W-1:0]    r_verify, n_verify;
    logic                r_compressed, n_compressed;
    logic [MAXLEN_W-1:0] r_remaining, n_remaining;
    t_status             r_verdict, n_verdict;

    logic [LEN_W-1:0]    len_full;
    logic [MAXLEN_W-1:0] rem_dec;
    logic                last;

    // payload countdown, saturating at zero
    assign rem_dec = (r_remaining != '0) ? r_remaining - MAXLEN_W'(1) : '0;
    assign last    = (rem_dec == '0);
    assign len_full = r_frame_len | {{(LEN_W-BYTE_W){1'b0}}, i_rx_byte};

    // header walk and payload handling
    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_frame_len  = r_frame_len;
        n_verify     = r_verify;
        n_compressed = r_compressed;
        n_remaining  = r_remaining;
        n_verdict    = r_verdict;
        o_res_valid  = 1'b0;
        o_res        = '{out_byte: '0, status: ST_OK, last: 1'b0};
        if (i_accept) begin
            unique case (r_hdr_pos)
                HP_LEN_HI: begin
                    n_frame_len = {i_rx_byte, {BYTE_W{1'b0}}};
                    n_hdr_pos   = HP_LEN_LO;
                end
                HP_LEN_LO: begin
                    n_frame_len = len_full;
                    // zero or negative length drops both bytes
                    if (len_full == '0 || len_full[LEN_W-1]) begin
                        n_hdr_pos = HP_LEN_HI;
                    end else begin
                        n_hdr_pos = HP_VER_HI;
                    end
                end
                HP_VER_HI: begin
                    n_verify  = {i_rx_byte, {BYTE_W{1'b0}}};
                    n_hdr_pos = HP_VER_LO;
                end
                HP_VER_LO: begin
                    n_verify  = r_verify | {{(LEN_W-BYTE_W){1'b0}}, i_rx_byte};
                    n_hdr_pos = HP_COMPRESS;
                end
                HP_COMPRESS: begin
                    n_compressed = (i_rx_byte == COMPRESS_MARK);
                    n_hdr_pos    = HP_CHECKSUM;
                end
                HP_CHECKSUM: begin
                    if ((r_frame_len ^ i_seed) != r_verify) begin
                        n_verdict = ST_VERIFY;
                    end else if (r_frame_len > {1'b0, i_max_payload}) begin
                        n_verdict = ST_TOO_LONG;
                    end else if (r_compressed) begin
                        n_verdict = ST_COMPRESSED;
                    end else begin
                        n_verdict = ST_OK;
                    end
                    n_remaining = r_frame_len[MAXLEN_W-1:0];
                    n_hdr_pos   = HP_PAYLOAD;
                end
                default: begin
                    n_remaining = rem_dec;
                    if (last) begin
                        n_hdr_pos = HP_LEN_HI;
                    end
                    if (r_verdict == ST_OK) begin
                        o_res_valid = 1'b1;
                        o_res       = '{out_byte: i_rx_byte, status: ST_OK, last: last};
                    end else if (last) begin
                        o_res_valid = 1'b1;
                        o_res       = '{out_byte: '0, status: r_verdict, last: 1'b1};
                    end
                end
            endcase
        end
    end

    // header position is the only state that needs a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos <= HP_LEN_HI;
        end else begin
            r_hdr_pos <= n_hdr_pos;
        end
    end

    // frame fields, always written before they are read
    always_ff @(posedge i_clk) begin
        r_frame_len  <= n_frame_len;
        r_verify     <= n_verify;
        r_compressed <= n_compressed;
        r_remaining  <= n_remaining;
        r_verdict    <= n_verdict;
    end

endmodule

FILE: hdl/lpd_checker.sv
module lpd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rx_valid,
    input  logic                           o_rx_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]     o_out_byte,
    input  logic [lpd_pkg::STATUS_W-1:0]   o_frame_status,
    input  logic                           o_frame_last
);
    import lpd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_byte) && $stable(o_frame_status) && $stable(o_frame_last))
        else $error("result changed while stalled");

    // flagged frames give one closing result with a zero byte
    a_flagged_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != ST_OK |-> o_frame_last && o_out_byte == '0)
        else $error("flagged result malformed");

    // a fresh result always follows a byte transfer
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("result without input transfer");

    // the input is never stalled while the output register is empty
    a_no_block_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_rx_ready)
        else $error("input stalled with empty output");

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import lpd_pkg::*;

    // deframer state plus its two registers
    typedef struct {
        logic [LEN_W-1:0]    seed;
        logic [MAXLEN_W-1:0] max_len;
        t_hdr_pos            pos;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    vcode;
        logic                cflag;
        logic [MAXLEN_W-1:0] remain;
        t_status             verdict;
    } t_deframer;

    typedef struct {
        logic [BYTE_W-1:0] data;
        int unsigned       gap;
    } t_rx_item;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 rx_valid = 1'b0;
    logic                 rx_ready;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic [STATUS_W-1:0]  frame_status;
    logic                 frame_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    length_prefixed_deframer_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_byte),
        .o_frame_status (frame_status),
        .o_frame_last   (frame_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    t_deframer   model_st;      // tracks the block, stepped on each accepted byte
    t_deframer   plan_st;       // tracks the stream as it is generated
    t_rx_item    pending[$];
    t_result     exp_results[$];
    t_rx_item    cur;
    t_result     got;
    t_result     want;
    bit          loaded = 1'b0;
    bit          quiet = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned holdoff_left = 0;
    int unsigned hold_count = 0;
    int unsigned n_queued = 0;
    int unsigned n_sent = 0;
    int unsigned n_results = 0;
    int unsigned n_writes = 0;
    int unsigned mismatches = 0;
    int unsigned closed[4] = '{0, 0, 0, 0};

    function automatic t_deframer deframer_reset();
        t_deframer s;
        s.seed    = SEED_RESET;
        s.max_len = MAX_PAYLOAD_RESET;
        s.pos     = HP_LEN_HI;
        s.len     = '0;
        s.vcode   = '0;
        s.cflag   = 1'b0;
        s.remain  = '0;
        s.verdict = ST_OK;
        return s;
    endfunction

    function automatic void apply_reg(inout t_deframer s, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        if (idx == CFG_SEED)
            s.seed = data;
        else if (idx == CFG_MAX_PAYLOAD)
            s.max_len = data[MAXLEN_W-1:0];
    endfunction

    // advance the deframer by one byte; returns 1 when a result is produced
    function automatic bit deframe_byte(inout t_deframer s, input logic [BYTE_W-1:0] b,
                                        output t_result r);
        bit fin;
        r = '0;
        case (s.pos)
            HP_LEN_HI: begin
                s.len = {b, 8'h00};
                s.pos = HP_LEN_LO;
                return 1'b0;
            end
            HP_LEN_LO: begin
                s.len = {s.len[15:8], b};
                // zero or negative length drops both bytes
                s.pos = (s.len == '0 || s.len[15]) ? HP_LEN_HI : HP_VER_HI;
                return 1'b0;
            end
            HP_VER_HI: begin
                s.vcode = {b, 8'h00};
                s.pos = HP_VER_LO;
                return 1'b0;
            end
            HP_VER_LO: begin
                s.vcode = {s.vcode[15:8], b};
                s.pos = HP_COMPRESS;
                return 1'b0;
            end
            HP_COMPRESS: begin
                s.cflag = (b == COMPRESS_MARK);
                s.pos = HP_CHECKSUM;
                return 1'b0;
            end
            HP_CHECKSUM: begin
                // verdict uses the registers as they are at the checksum byte
                if ((s.len ^ s.seed) != s.vcode)
                    s.verdict = ST_VERIFY;
                else if (s.len > {1'b0, s.max_len})
                    s.verdict = ST_TOO_LONG;
                else if (s.cflag)
                    s.verdict = ST_COMPRESSED;
                else
                    s.verdict = ST_OK;
                s.remain = s.len[MAXLEN_W-1:0];
                s.pos = HP_PAYLOAD;
                return 1'b0;
            end
            default: begin
            end
        endcase
        // payload, also reached for the unused position code
        if (s.remain != '0)
            s.remain = s.remain - 1'b1;
        fin = (s.remain == '0);
        if (fin)
            s.pos = HP_LEN_HI;
        if (s.verdict == ST_OK) begin
            r.out_byte = b;
            r.status   = ST_OK;
            r.last     = fin;
            return 1'b1;
        end
        if (fin) begin
            r.out_byte = '0;
            r.status   = s.verdict;
            r.last     = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // byte driver
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else begin
            if (rx_valid && rx_ready) begin
                if (deframe_byte(model_st, rx_byte, got))
                    exp_results.push_back(got);
                n_sent++;
            end
            if (!rx_valid || rx_ready) begin
                if (!loaded && pending.size() != 0) begin
                    cur = pending.pop_front();
                    gap_left = cur.gap;
                    loaded = 1'b1;
                end
                if (loaded && gap_left == 0) begin
                    rx_valid <= 1'b1;
                    rx_byte <= cur.data;
                    loaded = 1'b0;
                end else begin
                    if (loaded)
                        gap_left--;
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (frame_last)
                    closed[frame_status]++;
                if (exp_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: byte %h status %0d last %b",
                                 out_byte, frame_status, frame_last);
                end else begin
                    want = exp_results.pop_front();
                    if (out_byte != want.out_byte || frame_status != want.status ||
                        frame_last != want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: want %h/%0d/%b, got %h/%0d/%b",
                                     n_results, want.out_byte, want.status, want.last,
                                     out_byte, frame_status, frame_last);
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 3);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0) && (holdoff_left == 0);
        end
    end

    // long receiver hold-off every 250 results, so the output buffer fills
    always @(posedge clk) begin
        if (!rst_n) begin
            holdoff_left <= 0;
            hold_count = 0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (out_valid && out_ready) begin
            hold_count++;
            if (hold_count % 250 == 0)
                holdoff_left <= 120;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_rx_item it;
        t_result  dummy;
        it.data = b;
        it.gap  = quiet ? 0 : $urandom_range(0, 3);
        pending.push_back(it);
        void'(deframe_byte(plan_st, b, dummy));
        n_queued++;
    endtask

    task automatic send_header(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] vcode,
                               input logic [BYTE_W-1:0] comp, input logic [BYTE_W-1:0] chk);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(vcode[15:8]);
        send_byte(vcode[7:0]);
        send_byte(comp);
        send_byte(chk);
    endtask

    task automatic send_payload(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // one frame, good or flagged, a dropped length, or a burst of stray bytes
    task automatic random_frame();
        int unsigned kind;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] vcode;
        logic [BYTE_W-1:0] comp;
        logic [BYTE_W-1:0] b;
        bit short_max;
        kind = $urandom_range(0, 99);
        short_max = (plan_st.max_len < 64);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 64))
                                          : 16'($urandom_range(1, 8));
        comp = 8'($urandom_range(0, 255));
        if (kind < 55) begin
            // good or compressed
            if (len > {1'b0, plan_st.max_len})
                len = 16'($urandom_range(1, plan_st.max_len));
            if (kind < 45)
                comp = (comp == COMPRESS_MARK) ? 8'h00 : comp;
            else
                comp = COMPRESS_MARK;
            vcode = len ^ plan_st.seed;
        end else if (kind < 80) begin
            if (kind >= 65 && short_max)
                len = 16'(plan_st.max_len) + 16'($urandom_range(1, 6));
            vcode = len ^ plan_st.seed;
            // verify mismatch, alone or together with too long
            if (kind < 65 || kind >= 75 || !short_max)
                vcode = vcode ^ 16'($urandom_range(1, 65535));
        end else if (kind < 88) begin
            // zero or negative length
            len = ($urandom_range(0, 1) == 0) ? 16'h0000 : {1'b1, 15'($urandom)};
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            return;
        end else begin
            // stray bytes; a byte at a frame start keeps the next length short or negative
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
                b = 8'($urandom_range(0, 255));
                if (plan_st.pos == HP_LEN_HI)
                    b = b[0] ? 8'h00 : (b | 8'h80);
                send_byte(b);
            end
            while (plan_st.pos != HP_LEN_HI)
                send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_header(len, vcode, comp, 8'($urandom_range(0, 255)));
        send_payload(len[MAXLEN_W-1:0]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(model_st, idx, data);
        apply_reg(plan_st, idx, data);
        n_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait until every byte is taken and every result has come, or until the wait limit is reached
    task automatic settle(input int unsigned limit);
        int unsigned waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while ((pending.size() != 0 || loaded || rx_valid || exp_results.size() != 0) &&
                   waited < limit);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int unsigned start;
        model_st = deframer_reset();
        plan_st  = deframer_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, each verdict, dropped lengths
        send_header(16'd1, 16'd1 ^ SEED_RESET, 8'h00, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_header(16'd1, 16'd1 ^ SEED_RESET, COMPRESS_MARK, 8'h00);
        send_byte(8'h00);
        send_header(16'd1, SEED_RESET, 8'h00, 8'h00);
        send_byte(8'h5A);
        // registers change between the length and the checksum of a frame
        send_byte(8'h00);
        send_byte(8'h02);
        settle(100000);
        write_reg(CFG_SEED, 16'h0000);
        write_reg(CFG_MAX_PAYLOAD, 16'd1);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        send_header(16'd1, 16'd1, 8'h00, 8'h00);
        send_byte(8'h00);
        // verify and length both wrong
        send_header(16'd2, 16'h1234, 8'h00, 8'h00);
        send_payload(2);
        // a long frame, flagged too long
        quiet = 1'b1;
        send_header(16'd120, 16'd120, 8'h00, 8'h00);
        send_payload(120);

        // random phases, one register setting each
        for (int ph = 0; ph < 6; ph++) begin
            settle(100000);
            quiet = 1'b0;
            case (ph)
                0: begin
                    write_reg(CFG_SEED, SEED_RESET);
                    write_reg(CFG_MAX_PAYLOAD, 16'(MAX_PAYLOAD_RESET));
                end
                1: begin
                    write_reg(CFG_SEED, 16'h0000);
                    write_reg(CFG_MAX_PAYLOAD, 16'd1);
                end
                2: begin
                    write_reg(CFG_SEED, 16'hFFFF);
                    write_reg(CFG_MAX_PAYLOAD, 16'd32767);
                end
                3: begin
                    write_reg(CFG_SEED, 16'($urandom));
                    write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(2, 60)));
                    quiet = 1'b1;
                end
                4: begin
                    write_reg(CFG_SEED, 16'($urandom));
                    write_reg(CFG_MAX_PAYLOAD, 16'h8000 | 16'($urandom_range(100, 32767)));
                    write_reg(8'd2, 16'($urandom));
                    write_reg(8'hFF, 16'($urandom));
                end
                default: begin
                    write_reg(CFG_SEED, 16'($urandom));
                    write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(8, 40)));
                end
            endcase
            start = n_queued;
            if (ph == 2) begin
                // one long good frame keeps results flowing through the hold-offs
                send_header(16'd120, 16'd120 ^ plan_st.seed, 8'h00, 8'h00);
                send_payload(120);
            end
            while (n_queued - start < 100)
                random_frame();
        end

        settle(20000);
        if (exp_results.size() != 0) begin
            $display("%0d expected results never arrived", exp_results.size());
            mismatches += exp_results.size();
        end
        $display("run covered %0d bytes, %0d results and %0d register writes",
                 n_sent, n_results, n_writes);
        $display("frames closed: ok %0d, verify mismatch %0d, too long %0d, compressed %0d",
                 closed[ST_OK], closed[ST_VERIFY], closed[ST_TOO_LONG], closed[ST_COMPRESSED]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #10_000_000;
        $display("timeout after %0d bytes and %0d results", n_sent, n_results);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lpd_pkg.sv
hdl/lpd_parser.sv
hdl/length_prefixed_deframer_core.sv
hdl/lpd_checker.sv
test/tb.sv
